// File: rtl/srg_pkg.sv
package srg_pkg;

	// Table geometry
	localparam int CHANNELS_PER_SIDE = 9;
	localparam int TBL_DEPTH = 2 * CHANNELS_PER_SIDE;
	localparam int TBL_AW = $clog2(TBL_DEPTH);

	// Lanes carried by one move item
	localparam int NLANES = 3;
	localparam int LIDX_W = (NLANES > 1) ? $clog2(NLANES) : 1;

	// Field widths
	localparam int SIDE_W = 1;
	localparam int CNT_W = 2;
	localparam int CHAN_W = 4;
	localparam int ANGLE_W = 9;
	localparam int STEP_W = 6;
	localparam int INC_W = ANGLE_W + 1;
	localparam int REM_W = STEP_W;
	localparam int QCNT_W = $clog2(ANGLE_W + 1);

	typedef logic signed [INC_W-1:0] inc_t;

	typedef struct packed {
		logic valid;
		logic [CHAN_W-1:0] chan;
		logic [ANGLE_W-1:0] goal;
	} lane_info_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_MERGE,
		ST_EMIT,
		ST_WRITE
	} srg_state_t;

endpackage

// File: rtl/srg_move_if.sv
interface srg_move_if import srg_pkg::*; ();
	logic valid;
	logic ready;
	logic [SIDE_W-1:0] side;
	logic [CNT_W-1:0] lane_count;
	logic [CHAN_W-1:0] chan_a;
	logic [ANGLE_W-1:0] goal_a;
	logic [CHAN_W-1:0] chan_b;
	logic [ANGLE_W-1:0] goal_b;
	logic [CHAN_W-1:0] chan_c;
	logic [ANGLE_W-1:0] goal_c;
	logic [STEP_W-1:0] step_total;

	modport source (
		output valid, side, lane_count, chan_a, goal_a, chan_b, goal_b, chan_c, goal_c,
			step_total,
		input ready
	);

	modport sink (
		input valid, side, lane_count, chan_a, goal_a, chan_b, goal_b, chan_c, goal_c,
			step_total,
		output ready
	);
endinterface

// File: rtl/srg_step_if.sv
interface srg_step_if import srg_pkg::*; ();
	logic valid;
	logic ready;
	logic [SIDE_W-1:0] out_side;
	logic [STEP_W-1:0] step_index;
	logic [CHAN_W-1:0] out_chan_a;
	logic [ANGLE_W-1:0] angle_a;
	logic [CHAN_W-1:0] out_chan_b;
	logic [ANGLE_W-1:0] angle_b;
	logic [CHAN_W-1:0] out_chan_c;
	logic [ANGLE_W-1:0] angle_c;
	logic [NLANES-1:0] lane_valid;
	logic bad_channel;
	logic last;

	modport source (
		output valid, out_side, step_index, out_chan_a, angle_a, out_chan_b, angle_b,
			out_chan_c, angle_c, lane_valid, bad_channel, last,
		input ready
	);

	modport sink (
		input valid, out_side, step_index, out_chan_a, angle_a, out_chan_b, angle_b,
			out_chan_c, angle_c, lane_valid, bad_channel, last,
		output ready
	);
endinterface

// File: rtl/servo_group_ramp.sv
// Linear position ramp for groups of servo channels on two driver sides. A move item names a
// side, up to three channel/target lanes and a step count S; the block answers with S+1 step
// items, each carrying start + increment*k for every lane in range, the last one marked, and
// then stores the targets as the new channel angles. One move at a time: the block takes an
// item, reads the start angles of its lanes from the angle table (one read per lane), runs a
// bit-serial divider in each lane (one quotient bit per cycle), merges repeated channels, emits
// the steps and writes the targets back one lane per cycle. The table starts at zero after
// reset through per-entry valid bits, so no clearing pass is needed.
module servo_group_ramp import srg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	srg_move_if.sink   move_in,
	srg_step_if.source step_out
);

	srg_state_t state_q, state_d;
	logic [LIDX_W-1:0] idx_q, idx_d;
	logic [SIDE_W-1:0] side_q;
	logic [STEP_W-1:0] steps_q;
	logic [STEP_W-1:0] k_q;
	logic bad_q;
	logic [TBL_DEPTH-1:0] vbits_q;
	logic rd_pend_s1;
	logic [LIDX_W-1:0] rd_lane_s1;
	logic rd_hit_s1;

	logic take;
	logic rd_en;
	logic wr_en;
	logic step_adv;
	logic merge_load;
	logic emit_last;
	logic [TBL_AW-1:0] lane_addr;
	logic [ANGLE_W-1:0] rdata;
	logic [ANGLE_W-1:0] start_value;

	logic [CHAN_W-1:0] in_chan [NLANES];
	logic [ANGLE_W-1:0] in_goal [NLANES];
	logic [NLANES-1:0] used;
	logic [NLANES-1:0] chan_ok;
	lane_info_t lane_in [NLANES];
	lane_info_t info [NLANES];
	inc_t quot [NLANES];
	inc_t inc [NLANES];
	logic [ANGLE_W-1:0] angle [NLANES];
	logic [NLANES-1:0] done_v;
	logic [NLANES-1:0] start_we;
	logic [NLANES-1:0] vmask;

	// Unpack the lanes of the move item
	assign in_chan[0] = move_in.chan_a;
	assign in_chan[1] = move_in.chan_b;
	assign in_chan[2] = move_in.chan_c;
	assign in_goal[0] = move_in.goal_a;
	assign in_goal[1] = move_in.goal_b;
	assign in_goal[2] = move_in.goal_c;

	for (genvar i = 0; i < NLANES; i++) begin : g_lane
		assign used[i] = CNT_W'(i) < move_in.lane_count;
		assign chan_ok[i] = {1'b0, in_chan[i]} < (CHAN_W + 1)'(CHANNELS_PER_SIDE);
		assign lane_in[i].valid = used[i] && chan_ok[i];
		assign lane_in[i].chan = in_chan[i];
		assign lane_in[i].goal = in_goal[i];
		assign start_we[i] = rd_pend_s1 && (rd_lane_s1 == LIDX_W'(i));
		assign vmask[i] = info[i].valid;

		srg_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.take        (take),
			.lane_in     (lane_in[i]),
			.steps       (steps_q),
			.start_we    (start_we[i]),
			.start_value (start_value),
			.step_adv    (step_adv),
			.inc         (inc[i]),
			.info        (info[i]),
			.quot        (quot[i]),
			.done        (done_v[i]),
			.angle       (angle[i])
		);
	end

	srg_merge u_merge (
		.clk  (clk),
		.load (merge_load),
		.info (info),
		.quot (quot),
		.inc  (inc)
	);

	// Table entry of the lane in hand; unused lanes point at entry zero
	always_comb begin
		lane_addr = '0;
		if (info[idx_q].valid) begin
			lane_addr = side_q[0] ? TBL_AW'(info[idx_q].chan) + TBL_AW'(CHANNELS_PER_SIDE)
				: TBL_AW'(info[idx_q].chan);
		end
	end

	srg_ram #(
		.WIDTH (ANGLE_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (wr_en),
		.waddr (lane_addr),
		.wdata (info[idx_q].goal),
		.re    (rd_en),
		.raddr (lane_addr),
		.rdata (rdata)
	);

	// An entry never written reads as zero
	assign start_value = rd_hit_s1 ? rdata : '0;

	// Sequencer: next state and strobes
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		take = 1'b0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		step_adv = 1'b0;
		merge_load = 1'b0;
		move_in.ready = 1'b0;
		step_out.valid = 1'b0;
		emit_last = k_q == steps_q;
		unique case (state_q)
			ST_IDLE: begin
				move_in.ready = 1'b1;
				if (move_in.valid) begin
					take = 1'b1;
					idx_d = '0;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (idx_q == LIDX_W'(NLANES - 1)) begin
					idx_d = '0;
					state_d = ST_DIV;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (&done_v) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				merge_load = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				step_out.valid = 1'b1;
				if (step_out.ready) begin
					if (emit_last) begin
						idx_d = '0;
						state_d = ST_WRITE;
					end else begin
						step_adv = 1'b1;
					end
				end
			end
			ST_WRITE: begin
				wr_en = info[idx_q].valid;
				if (idx_q == LIDX_W'(NLANES - 1)) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			k_q <= '0;
			rd_pend_s1 <= 1'b0;
			vbits_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			rd_pend_s1 <= rd_en;
			if (take) begin
				k_q <= '0;
			end else if (step_adv) begin
				k_q <= k_q + 1'b1;
			end
			if (wr_en) begin
				vbits_q[lane_addr] <= 1'b1;
			end
		end
	end

	// Hold move fields and the read tag
	always_ff @(posedge clk) begin
		if (take) begin
			side_q <= move_in.side;
			steps_q <= move_in.step_total;
			bad_q <= |(used & ~chan_ok);
		end
		rd_lane_s1 <= idx_q;
		rd_hit_s1 <= vbits_q[lane_addr];
	end

	// Result fields from registers; the last flag compares the step counter with the step count
	assign step_out.out_side = side_q;
	assign step_out.step_index = k_q;
	assign step_out.out_chan_a = info[0].chan;
	assign step_out.angle_a = angle[0];
	assign step_out.out_chan_b = info[1].chan;
	assign step_out.angle_b = angle[1];
	assign step_out.out_chan_c = info[2].chan;
	assign step_out.angle_c = angle[2];
	assign step_out.lane_valid = vmask;
	assign step_out.bad_channel = bad_q;
	assign step_out.last = emit_last;

endmodule

// File: rtl/srg_ram.sv
module srg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/srg_lane.sv
module srg_lane import srg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  lane_info_t         lane_in,
	input  logic [STEP_W-1:0]  steps,
	input  logic               start_we,
	input  logic [ANGLE_W-1:0] start_value,
	input  logic               step_adv,
	input  inc_t               inc,
	output lane_info_t         info,
	output inc_t               quot,
	output logic               done,
	output logic [ANGLE_W-1:0] angle
);

	lane_info_t info_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [ANGLE_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [ANGLE_W-1:0] quo_q;
	logic neg_q;
	logic [QCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [ANGLE_W-1:0] start_eff;
	inc_t diff;
	inc_t mag;
	logic [REM_W:0] trial;
	logic fits;
	inc_t quot_pos;

	// Signed distance to the goal and its magnitude
	always_comb begin
		start_eff = info_q.valid ? start_value : '0;
		diff = inc_t'({1'b0, info_q.goal}) - inc_t'({1'b0, start_eff});
		mag = diff[INC_W-1] ? -diff : diff;
	end

	// One restoring division step
	always_comb begin
		trial = {rem_q, dvd_q[ANGLE_W-1]};
		fits = trial >= {1'b0, steps};
	end

	// Hold move fields; drop the channel of an unused lane
	always_ff @(posedge clk) begin
		if (take) begin
			info_q.valid <= lane_in.valid;
			info_q.chan <= lane_in.valid ? lane_in.chan : '0;
			info_q.goal <= lane_in.goal;
		end
	end

	// Divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start_we) begin
			busy_q <= 1'b1;
			cnt_q <= QCNT_W'(ANGLE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == QCNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Divider datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start_we) begin
			dvd_q <= mag[ANGLE_W-1:0];
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= diff[INC_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ANGLE_W-2:0], 1'b0};
			rem_q <= fits ? REM_W'(trial - {1'b0, steps}) : trial[REM_W-1:0];
			quo_q <= {quo_q[ANGLE_W-2:0], fits};
		end
	end

	// Load the start angle, then advance by the merged increment
	always_ff @(posedge clk) begin
		if (start_we) begin
			angle_q <= start_eff;
		end else if (step_adv) begin
			angle_q <= angle_q + inc[ANGLE_W-1:0];
		end
	end

	// Truncating quotient with the sign restored; no steps means no increment
	always_comb begin
		quot_pos = inc_t'({1'b0, quo_q});
		if (steps == '0) begin
			quot = '0;
		end else begin
			quot = neg_q ? -quot_pos : quot_pos;
		end
	end

	assign info = info_q;
	assign done = done_q;
	assign angle = angle_q;

endmodule

// File: rtl/srg_merge.sv
module srg_merge import srg_pkg::*; (
	input  logic       clk,
	input  logic       load,
	input  lane_info_t info [NLANES],
	input  inc_t       quot [NLANES],
	output inc_t       inc [NLANES]
);

	inc_t sel [NLANES];
	inc_t inc_q [NLANES];

	// Pick the increment of the latest valid lane on the same channel
	always_comb begin
		for (int i = 0; i < NLANES; i++) begin
			sel[i] = info[i].valid ? quot[i] : '0;
			for (int j = i + 1; j < NLANES; j++) begin
				if (info[i].valid && info[j].valid && info[j].chan == info[i].chan) begin
					sel[i] = quot[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			inc_q <= sel;
		end
	end

	assign inc = inc_q;

endmodule

// File: rtl/srg_check.sv
module srg_check import srg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [STEP_W-1:0]  step_index,
	input logic [CHAN_W-1:0]  out_chan_a,
	input logic [ANGLE_W-1:0] angle_a,
	input logic [NLANES-1:0]  lane_valid,
	input logic               last
);

	// No new move is taken while steps are still going out
	a_no_take_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(in_valid && in_ready))
		else $error("move taken while step items pending");

	// Step indices count up by one within a move
	a_index_advances: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> step_index == STEP_W'($past(step_index) + 1'b1))
		else $error("step index did not advance");

	// The final step item closes the move
	a_last_ends_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("step items continue after last");

	// An unused lane a shows zeros
	a_idle_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lane_valid[0] |-> out_chan_a == '0 && angle_a == '0)
		else $error("unused lane carries data");

	// A used lane a names a channel in range
	a_chan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lane_valid[0] |-> {1'b0, out_chan_a} < (CHAN_W + 1)'(CHANNELS_PER_SIDE))
		else $error("valid lane with channel out of range");

endmodule

bind servo_group_ramp srg_check u_srg_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (move_in.valid),
	.in_ready   (move_in.ready),
	.out_valid  (step_out.valid),
	.out_ready  (step_out.ready),
	.step_index (step_out.step_index),
	.out_chan_a (step_out.out_chan_a),
	.angle_a    (step_out.angle_a),
	.lane_valid (step_out.lane_valid),
	.last       (step_out.last)
);
